[src/ssmf_pkg.sv]
package ssmf_pkg;

  localparam logic [2:0] MODE_UNIT    = 3'd0;
  localparam logic [2:0] MODE_TIRE    = 3'd1;
  localparam logic [2:0] MODE_SPEED   = 3'd2;
  localparam logic [2:0] MODE_DIST    = 3'd3;
  localparam logic [2:0] MODE_ELAPSED = 3'd4;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_DP    = 8'h80;
  localparam logic [7:0] ANODE_ALL = 8'h0F;

  // Values formatted at capture; every quotient here is one constant
  // multiplication away from the raw field.
  typedef struct packed {
    logic [2:0]  mode;
    logic        unit;
    logic        spd_small;
    logic [3:0]  spd_hi;
    logic [6:0]  spd_q10;
    logic [3:0]  spd_r10;
    logic        avg_small;
    logic [3:0]  avg_hi;
    logic [6:0]  avg_q10;
    logic [3:0]  avg_r10;
    logic [3:0]  tire_h;
    logic [6:0]  tire_q10;
    logic [3:0]  tire_r10;
    logic        dist_small;
    logic [4:0]  dist_h;
    logic [7:0]  dist_q100;
    logic [10:0] dist_q10;
    logic [3:0]  dist_r10;
    logic [10:0] minutes;
    logic [5:0]  seconds;
  } prep_t;

  // x / 10, exact for all 16-bit x.
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd52429;
    return 16'(p >> 19);
  endfunction

  function automatic logic [3:0] mod10(input logic [15:0] x);
    logic [15:0] q;
    q = div10(x);
    return 4'(x - 16'(q * 16'd10));
  endfunction

  // x / 100, exact for all 16-bit x.
  function automatic logic [15:0] div100(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd83887;
    return 16'(p >> 23);
  endfunction

  // x / 1000, exact for all 14-bit x.
  function automatic logic [4:0] div1000(input logic [13:0] x);
    logic [29:0] p;
    p = {16'd0, x} * 30'd16778;
    return 5'(p >> 24);
  endfunction

  // x / 60, exact for all 16-bit x.
  function automatic logic [10:0] div60(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd34953;
    return 11'(p >> 21);
  endfunction

  function automatic logic [7:0] seg_of(input logic [7:0] d);
    logic [7:0] s;
    case (d)
      8'd0:    s = 8'b00111111;
      8'd1:    s = 8'b00000110;
      8'd2:    s = 8'b01011011;
      8'd3:    s = 8'b01001111;
      8'd4:    s = 8'b01100110;
      8'd5:    s = 8'b01101101;
      8'd6:    s = 8'b01111101;
      8'd7:    s = 8'b00000111;
      8'd8:    s = 8'b01111111;
      8'd9:    s = 8'b01101111;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

[src/ssmf_prep.sv]
module ssmf_prep (
  input  logic [2:0]     display_mode,
  input  logic [9:0]     speed_tenths,
  input  logic [9:0]     avg_speed_tenths,
  input  logic [13:0]    distance_tenths,
  input  logic [15:0]    elapsed_seconds,
  input  logic [9:0]     tire_size,
  input  logic           speed_unit,
  output ssmf_pkg::prep_t prep
);

  logic [15:0] secs_m60;

  always_comb begin
    prep.mode = display_mode;
    prep.unit = speed_unit;

    prep.spd_small = (speed_tenths != 10'd0) && (speed_tenths < 10'd10);
    prep.spd_hi    = 4'(ssmf_pkg::div100(16'(speed_tenths)));
    prep.spd_q10   = 7'(ssmf_pkg::div10(16'(speed_tenths)));
    prep.spd_r10   = ssmf_pkg::mod10(16'(speed_tenths));

    prep.avg_small = (avg_speed_tenths != 10'd0) && (avg_speed_tenths < 10'd10);
    prep.avg_hi    = 4'(ssmf_pkg::div100(16'(avg_speed_tenths)));
    prep.avg_q10   = 7'(ssmf_pkg::div10(16'(avg_speed_tenths)));
    prep.avg_r10   = ssmf_pkg::mod10(16'(avg_speed_tenths));

    prep.tire_h    = 4'(ssmf_pkg::div100(16'(tire_size)));
    prep.tire_q10  = 7'(ssmf_pkg::div10(16'(tire_size)));
    prep.tire_r10  = ssmf_pkg::mod10(16'(tire_size));

    prep.dist_small = (distance_tenths != 14'd0) && (distance_tenths < 14'd10);
    prep.dist_h     = ssmf_pkg::div1000(distance_tenths);
    prep.dist_q100  = 8'(ssmf_pkg::div100(16'(distance_tenths)));
    prep.dist_q10   = 11'(ssmf_pkg::div10(16'(distance_tenths)));
    prep.dist_r10   = ssmf_pkg::mod10(16'(distance_tenths));

    prep.minutes = ssmf_pkg::div60(elapsed_seconds);
    secs_m60     = 16'(prep.minutes * 16'd60);
    prep.seconds = 6'(elapsed_seconds - secs_m60);
  end

endmodule

[src/ssmf_fmt.sv]
module ssmf_fmt (
  input  ssmf_pkg::prep_t  prep,
  input  logic [3:0][7:0]  cur,
  output logic [3:0][7:0]  pat
);

  logic [3:0] spd_lo;
  logic [3:0] avg_lo;
  logic [3:0] tire_t;
  logic [3:0] dist_t;
  logic [3:0] dist_o;
  logic [7:0] min_hi;
  logic [3:0] min_lo;
  logic [7:0] sec_hi;
  logic [3:0] sec_lo;

  always_comb begin
    spd_lo = ssmf_pkg::mod10(16'(prep.spd_q10));
    avg_lo = ssmf_pkg::mod10(16'(prep.avg_q10));
    tire_t = ssmf_pkg::mod10(16'(prep.tire_q10));
    dist_t = ssmf_pkg::mod10(16'(prep.dist_q100));
    dist_o = ssmf_pkg::mod10(16'(prep.dist_q10));
    min_hi = 8'(ssmf_pkg::div10(16'(prep.minutes)));
    min_lo = ssmf_pkg::mod10(16'(prep.minutes));
    sec_hi = 8'(ssmf_pkg::div10(16'(prep.seconds)));
    sec_lo = ssmf_pkg::mod10(16'(prep.seconds));

    pat = cur;
    case (prep.mode)
      ssmf_pkg::MODE_UNIT: begin
        pat[0] = ssmf_pkg::SEG_BLANK;
        pat[1] = ssmf_pkg::SEG_BLANK;
        pat[2] = ssmf_pkg::SEG_BLANK;
        pat[3] = ssmf_pkg::seg_of(8'(prep.unit) + 8'd1);
      end
      ssmf_pkg::MODE_TIRE: begin
        pat[0] = ssmf_pkg::SEG_BLANK;
        pat[1] = (prep.tire_h != 4'd0) ? ssmf_pkg::seg_of(8'(prep.tire_h))
                                       : ssmf_pkg::SEG_BLANK;
        pat[2] = ssmf_pkg::seg_of(8'(tire_t));
        pat[3] = ssmf_pkg::seg_of(8'(prep.tire_r10));
      end
      ssmf_pkg::MODE_SPEED: begin
        // A nonzero value below one whole unit reads as "0." followed by tenths.
        if (prep.spd_small) begin
          pat[0] = ssmf_pkg::seg_of(8'd0) | ssmf_pkg::SEG_DP;
          pat[1] = ssmf_pkg::seg_of(8'(prep.spd_r10));
        end else begin
          pat[0] = ssmf_pkg::seg_of(8'(prep.spd_hi));
          pat[1] = ssmf_pkg::seg_of(8'(spd_lo));
        end
        if (prep.avg_small) begin
          pat[2] = ssmf_pkg::seg_of(8'd0) | ssmf_pkg::SEG_DP;
          pat[3] = ssmf_pkg::seg_of(8'(prep.avg_r10));
        end else begin
          pat[2] = ssmf_pkg::seg_of(8'(prep.avg_hi));
          pat[3] = ssmf_pkg::seg_of(8'(avg_lo));
        end
      end
      ssmf_pkg::MODE_DIST: begin
        if (prep.dist_small) begin
          pat[0] = ssmf_pkg::SEG_BLANK;
          pat[1] = ssmf_pkg::SEG_BLANK;
          pat[2] = ssmf_pkg::seg_of(8'd0) | ssmf_pkg::SEG_DP;
          pat[3] = ssmf_pkg::seg_of(8'(prep.dist_r10));
        end else begin
          pat[0] = (prep.dist_h != 5'd0) ? ssmf_pkg::seg_of(8'(prep.dist_h))
                                         : ssmf_pkg::SEG_BLANK;
          pat[1] = ssmf_pkg::seg_of(8'(dist_t));
          pat[2] = ssmf_pkg::seg_of(8'(dist_o)) | ssmf_pkg::SEG_DP;
          pat[3] = ssmf_pkg::seg_of(8'(prep.dist_r10));
        end
      end
      ssmf_pkg::MODE_ELAPSED: begin
        pat[0] = ssmf_pkg::seg_of(min_hi);
        pat[1] = ssmf_pkg::seg_of(8'(min_lo));
        pat[2] = ssmf_pkg::seg_of(sec_hi);
        pat[3] = ssmf_pkg::seg_of(8'(sec_lo));
      end
      default: begin
        pat = cur;
      end
    endcase
  end

endmodule

[src/seven_segment_mode_formatter_scan.sv]
// An accepted request is registered in the capture stage, then its digit in the output register.
// Throughput: one request per cycle while the output is not stalled; each request is one scan tick driving one digit.
// The digit splits are done at capture and in the formatter, each quotient by one constant multiply.
// Reset clears the scan position to the rightmost digit and all four patterns to blank,
// and empties both pipeline registers.
module seven_segment_mode_formatter_scan (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  display_mode,
  input  logic [9:0]  speed_tenths,
  input  logic [9:0]  avg_speed_tenths,
  input  logic [13:0] distance_tenths,
  input  logic [15:0] elapsed_seconds,
  input  logic [9:0]  tire_size,
  input  logic        speed_unit,
  input  logic [7:0]  port_a_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  port_a_out,
  output logic [7:0]  port_b_out,
  output logic [1:0]  digit_position
);

  ssmf_pkg::prep_t prep_in;
  ssmf_pkg::prep_t prep_reg;
  logic [7:0]      pa_reg;
  logic            stage_valid;

  logic [1:0]      scan_position;
  logic [3:0][7:0] digit_patterns;
  logic [3:0][7:0] digit_patterns_next;
  logic [3:0][7:0] fresh;
  logic [7:0]      pat;
  logic            advance;

  ssmf_prep u_prep (
    .display_mode     (display_mode),
    .speed_tenths     (speed_tenths),
    .avg_speed_tenths (avg_speed_tenths),
    .distance_tenths  (distance_tenths),
    .elapsed_seconds  (elapsed_seconds),
    .tire_size        (tire_size),
    .speed_unit       (speed_unit),
    .prep             (prep_in)
  );

  ssmf_fmt u_fmt (
    .prep (prep_reg),
    .cur  (digit_patterns),
    .pat  (fresh)
  );

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // Patterns are reformatted only on the tick that drives position zero.
  assign digit_patterns_next = (scan_position == 2'd0) ? fresh : digit_patterns;
  assign pat                 = digit_patterns_next[~scan_position];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prep_reg <= prep_in;
      pa_reg   <= port_a_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position  <= 2'd0;
      digit_patterns <= '0;
    end else if (advance) begin
      scan_position  <= scan_position + 2'd1;
      digit_patterns <= digit_patterns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      port_a_out     <= (pa_reg | ssmf_pkg::ANODE_ALL) & ~(8'h01 << scan_position);
      port_b_out     <= ~pat;
      digit_position <= scan_position;
    end
  end

endmodule
